>>> src/arc_pkg.sv
package arc_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int RECURRENCE_STEPS = 16;

  localparam int FRAC_BITS  = SAMPLE_BITS - 1;
  localparam int STEPS      = RECURRENCE_STEPS;
  localparam int FIELD_W    = 16;
  localparam int ROOT_W     = 31;
  localparam int ROOT_CELLS = ROOT_W;
  localparam int RAD_W      = ROOT_W + 1;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int EX_W       = 30;
  localparam int K_W        = $clog2(FRAC_BITS + 1);
  localparam int NL_W       = K_W + STEPS;
  localparam int MAG_W      = NL_W + EX_W - (STEPS - 6);
  localparam int SH_W       = MAG_W - 30 + 1;
  localparam int FAR_SHIFT  = 40;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [15:0] FULL_OUT  = 16'h8000;

  localparam logic [7:0] CFG_DEAD_ZONE   = 8'd0;
  localparam logic [7:0] CFG_FULL_SCALE  = 8'd1;
  localparam logic [7:0] CFG_CURVE_SHAPE = 8'd2;
  localparam logic [7:0] CFG_OUTPUT_GAIN = 8'd3;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_FULL,
    CLS_FRAC
  } cls_e;

  typedef struct packed {
    cls_e                  cls;
    logic [FIELD_W-1:0]    den;
    logic [FIELD_W-1:0]    drem;
    logic [FRAC_BITS-1:0]  quot;
    logic signed [3:0]     na;
    logic [EX_W-1:0]       ex;
    logic [K_W-1:0]        k;
    logic [ROOT_W-1:0]     m;
    logic [STEPS-1:0]      fr;
    logic [MAG_W-1:0]      mag;
    logic [STEPS-1:0]      dig;
    logic                  far;
    logic [5:0]            shamt;
    logic [RAD_W-1:0]      rad;
    logic [ROOT_W-1:0]     root;
    logic [SREM_W-1:0]     srem;
  } item_t;

  // shift that brings the top set bit of the quotient to bit 30
  function automatic logic [K_W-1:0] norm_shift(input logic [FRAC_BITS-1:0] b);
    logic [K_W-1:0] k;
    k = K_W'(FRAC_BITS);
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (b[i]) begin
        k = K_W'(FRAC_BITS - i);
      end
    end
    return k;
  endfunction

endpackage

>>> src/axis_response_curve.sv
// throughput: one item per cycle unless the output stalls and the skid register is full;
// every stage is a cell of a single flow-through pipeline
// the square-root cells of the two exp2 chains (31 per digit) set the latency
// a stalled output holds one more item in a skid register, then input ready drops
// reset clears all valid bits and loads the register defaults
// (dead zone 0, full scale 1.0, linear curve, gain 1.0)
module axis_response_curve (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // axis_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // shaped_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import arc_pkg::*;

  logic [14:0]        dz_q;
  logic [15:0]        sat_q;
  logic signed [14:0] shape_q;
  logic [15:0]        gain_q;

  logic en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= 15'd0;
      sat_q   <= 16'h8000;
      shape_q <= 15'sd0;
      gain_q  <= 16'h4000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEAD_ZONE:   dz_q    <= cfg_data_i[14:0];
        CFG_FULL_SCALE:  sat_q   <= cfg_data_i;
        CFG_CURVE_SHAPE: shape_q <= cfg_data_i[14:0];
        CFG_OUTPUT_GAIN: gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front cell: classify, divisor, exponent of e^L
  logic               fr_v_q;
  item_t              fr_q, fr_d;
  logic signed [17:0] num;
  logic [15:0]        satv, den;
  logic signed [46:0] prod;
  logic [33:0]        t;

  always_comb begin
    num  = {{2{s_axis_tdata[15]}}, s_axis_tdata} - {3'b000, dz_q};
    satv = (sat_q <= {1'b0, dz_q}) ? ({1'b0, dz_q} + 16'd1) : sat_q;
    den  = satv - {1'b0, dz_q};
    prod = 47'(shape_q) * 47'($signed({1'b0, LOG2E_Q30}));
    t    = prod[45:12];
    fr_d = '0;
    if (num[17] || (num == 18'sd0)) begin
      fr_d.cls = CLS_ZERO;
    end else if (num >= $signed({2'b00, den})) begin
      fr_d.cls = CLS_FULL;
    end else begin
      fr_d.cls = CLS_FRAC;
    end
    fr_d.den  = den;
    fr_d.drem = num[15:0];
    fr_d.dig  = t[29 -: STEPS];
    fr_d.na   = t[33:30];
    fr_d.root = ONE_Q30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else if (en) begin
      fr_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_q <= fr_d;
    end
  end

  // e^L through the first exp2 chain
  logic  ca_v;
  item_t ca_it;

  arc_exp2_chain u_exp_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v_q),
    .item_i  (fr_q),
    .valid_o (ca_v),
    .item_o  (ca_it)
  );

  logic        ex_v_q;
  item_t       ex_q, ex_d;
  logic [37:0] ew;
  logic [3:0]  nneg;

  always_comb begin
    ew   = {7'b0, ca_it.root};
    nneg = 4'd0 - ca_it.na;
    if (!ca_it.na[3]) begin
      ew = ew << ca_it.na[2:0];
    end else begin
      ew = ew >> nneg;
    end
    ex_d    = ca_it;
    ex_d.ex = ew[35:6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q <= 1'b0;
    end else if (en) begin
      ex_v_q <= ca_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q <= ex_d;
    end
  end

  // base by restoring division
  logic [FRAC_BITS:0] dv_v;
  item_t              dv_it [FRAC_BITS+1];

  assign dv_v[0]  = ex_v_q;
  assign dv_it[0] = ex_q;

  for (genvar gd = 0; gd < FRAC_BITS; gd++) begin : g_div
    arc_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[gd]),
      .item_i  (dv_it[gd]),
      .valid_o (dv_v[gd+1]),
      .item_o  (dv_it[gd+1])
    );
  end

  // normalize the base for log2
  logic        nm_v_q;
  item_t       nm_q, nm_d;
  logic [30:0] mb;

  always_comb begin
    nm_d   = dv_it[FRAC_BITS];
    nm_d.k = norm_shift(nm_d.quot);
    mb     = 31'(nm_d.quot) << (30 - FRAC_BITS);
    nm_d.m = mb << nm_d.k;
    nm_d.fr = '0;
    if ((nm_d.cls == CLS_FRAC) && (nm_d.quot == '0)) begin
      nm_d.cls = CLS_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_v_q <= 1'b0;
    end else if (en) begin
      nm_v_q <= dv_v[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_q <= nm_d;
    end
  end

  // log2 fraction digits by squaring
  logic [STEPS:0] lg_v;
  item_t          lg_it [STEPS+1];

  assign lg_v[0]  = nm_v_q;
  assign lg_it[0] = nm_q;

  for (genvar gl = 0; gl < STEPS; gl++) begin : g_log
    logic        v_q;
    item_t       it_q, it_d;
    logic [61:0] sq;
    logic [31:0] m2;

    always_comb begin
      sq   = {31'b0, lg_it[gl].m} * {31'b0, lg_it[gl].m};
      m2   = sq[61:30];
      it_d = lg_it[gl];
      it_d.m  = m2[31] ? m2[31:1] : m2[30:0];
      it_d.fr = {lg_it[gl].fr[STEPS-2:0], m2[31]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= lg_v[gl];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        it_q <= it_d;
      end
    end

    assign lg_v[gl+1]  = v_q;
    assign lg_it[gl+1] = it_q;
  end

  // exponent magnitude = -log2(b) * e^L
  logic                 mu_v_q;
  item_t                mu_q, mu_d;
  logic [NL_W-1:0]      nl;
  logic [NL_W+EX_W-1:0] mp;

  always_comb begin
    nl   = {lg_it[STEPS].k, {STEPS{1'b0}}} - {{K_W{1'b0}}, lg_it[STEPS].fr};
    mp   = {{EX_W{1'b0}}, nl} * {{NL_W{1'b0}}, lg_it[STEPS].ex};
    mu_d = lg_it[STEPS];
    mu_d.mag = mp[NL_W+EX_W-1 : STEPS-6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_v_q <= 1'b0;
    end else if (en) begin
      mu_v_q <= lg_v[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_q <= mu_d;
    end
  end

  // split the negated exponent into shift and fraction digits
  logic             ng_v_q;
  item_t            ng_q, ng_d;
  logic [MAG_W-1:0] ny;
  logic [SH_W-1:0]  sh;

  always_comb begin
    ny   = MAG_W'(0) - mu_q.mag;
    sh   = {1'b0, mu_q.mag[MAG_W-1:30]} + SH_W'(|mu_q.mag[29:0]);
    ng_d = mu_q;
    ng_d.dig   = ny[29 -: STEPS];
    ng_d.far   = sh >= SH_W'(FAR_SHIFT);
    ng_d.shamt = sh[5:0];
    ng_d.root  = ONE_Q30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ng_v_q <= 1'b0;
    end else if (en) begin
      ng_v_q <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ng_q <= ng_d;
    end
  end

  logic  cb_v;
  item_t cb_it;

  arc_exp2_chain u_exp_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ng_v_q),
    .item_i  (ng_q),
    .valid_o (cb_v),
    .item_o  (cb_it)
  );

  // power
  logic        pw_v_q;
  logic [30:0] pw_q, pw_d;

  always_comb begin
    case (cb_it.cls)
      CLS_ZERO: pw_d = '0;
      CLS_FULL: pw_d = ONE_Q30;
      default:  pw_d = cb_it.far ? 31'd0 : (cb_it.root >> cb_it.shamt);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_v_q <= 1'b0;
    end else if (en) begin
      pw_v_q <= cb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q <= pw_d;
    end
  end

  // gain, clamp, output register with skid
  logic [46:0] gp;
  logic [17:0] res;
  logic [15:0] shaped;

  always_comb begin
    gp     = {16'b0, pw_q} * {31'b0, gain_q};
    res    = gp[46:29];
    shaped = (res > 18'(FULL_OUT)) ? FULL_OUT : res[15:0];
  end

  logic        out_v_q, out_v_d;
  logic [15:0] out_q, out_d;
  logic        skid_v_q, skid_v_d;
  logic [15:0] skid_q, skid_d;
  logic        inc_v;

  assign en    = !skid_v_q;
  assign inc_v = en && pw_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = inc_v;
        out_d   = shaped;
      end
    end else if (inc_v) begin
      skid_v_d = 1'b1;
      skid_d   = shaped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid item without output item");

  a_skid_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !s_axis_tready)
    else $error("input taken while skid is full");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid filled without output stall");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= FULL_OUT))
    else $error("shaped value above full scale");

endmodule

>>> src/arc_root_cell.sv
module arc_root_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  arc_pkg::item_t item_i,
  output logic          valid_o,
  output arc_pkg::item_t item_o
);
  import arc_pkg::*;

  logic              v_q;
  item_t             it_q, it_d;
  logic [SREM_W+1:0] rem4, trial;
  logic              ge;

  // one root bit of the floor square root
  always_comb begin
    rem4  = {item_i.srem, item_i.rad[RAD_W-1 -: 2]};
    trial = {2'b00, item_i.root, 2'b01};
    ge    = rem4 >= trial;
    it_d  = item_i;
    it_d.srem = ge ? SREM_W'(rem4 - trial) : SREM_W'(rem4);
    it_d.root = {item_i.root[ROOT_W-2:0], ge};
    it_d.rad  = item_i.rad << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_q <= it_d;
    end
  end

  assign valid_o = v_q;
  assign item_o  = it_q;

endmodule

>>> src/arc_exp2_chain.sv
module arc_exp2_chain (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  arc_pkg::item_t item_i,
  output logic          valid_o,
  output arc_pkg::item_t item_o
);
  import arc_pkg::*;

  localparam int NCELL = STEPS * ROOT_CELLS;

  logic [NCELL:0] v;
  item_t          it [NCELL+1];

  assign v[0]  = valid_i;
  assign it[0] = item_i;

  for (genvar gi = 0; gi < STEPS; gi++) begin : g_digit
    for (genvar gj = 0; gj < ROOT_CELLS; gj++) begin : g_cell
      localparam int C = gi * ROOT_CELLS + gj;
      item_t cin;
      if (gj == 0) begin : g_prep
        // doubles r for a set digit, then starts a fresh root
        always_comb begin
          cin      = it[C];
          cin.rad  = it[C].dig[gi] ? {it[C].root, 1'b0} : {1'b0, it[C].root};
          cin.root = '0;
          cin.srem = '0;
        end
      end else begin : g_pass
        assign cin = it[C];
      end
      arc_root_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en_i),
        .valid_i (v[C]),
        .item_i  (cin),
        .valid_o (v[C+1]),
        .item_o  (it[C+1])
      );
    end
  end

  assign valid_o = v[NCELL];
  assign item_o  = it[NCELL];

endmodule

>>> src/arc_div_cell.sv
module arc_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  arc_pkg::item_t item_i,
  output logic          valid_o,
  output arc_pkg::item_t item_o
);
  import arc_pkg::*;

  logic             v_q;
  item_t            it_q, it_d;
  logic [FIELD_W:0] r2;
  logic             ge;

  // one quotient bit of the restoring divide
  always_comb begin
    r2   = {item_i.drem, 1'b0};
    ge   = r2 >= {1'b0, item_i.den};
    it_d = item_i;
    it_d.drem = ge ? FIELD_W'(r2 - {1'b0, item_i.den}) : r2[FIELD_W-1:0];
    it_d.quot = {item_i.quot[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_q <= it_d;
    end
  end

  assign valid_o = v_q;
  assign item_o  = it_q;

endmodule
